/* rtl/core/sbph_pkg.sv */
// Shared types and constants for the spectrum bin peak-hold core.
// Used by sbph_div and spectrum_bin_peak_hold_core; depends on nothing else.
`default_nettype none

package sbph_pkg;

    localparam int BINS      = 240;
    localparam int FREQ_W    = 32;
    localparam int LEVEL_W   = 16;
    localparam int BIN_W     = 8;
    localparam int NUM_W     = FREQ_W + BIN_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [BIN_W-1:0]   NO_BIN    = 8'd255;
    localparam logic [LEVEL_W-1:0] FLOOR_MAX = 16'hFFFF;
    localparam logic [NUM_W-1:0]   BIN_SCALE = NUM_W'(BINS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                command;
        logic [FREQ_W-1:0]   frequency;
        logic [LEVEL_W-1:0]  signal_level;
        logic [LEVEL_W-1:0]  noise_level;
        logic                squelch_open;
    } item_t;

    typedef struct packed {
        logic [BIN_W-1:0]    bin_index;
        logic [LEVEL_W-1:0]  bin_peak;
        logic [LEVEL_W-1:0]  bin_floor;
        logic                bin_marker;
        logic [BIN_W-1:0]    filled_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/sbph_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on sbph_pkg for the operand and quotient widths.
`default_nettype none

module sbph_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [sbph_pkg::NUM_W-1:0]  dividend,
    input  wire logic [sbph_pkg::FREQ_W-1:0] divisor,
    output logic                             done,
    output logic [sbph_pkg::BIN_W-1:0]       quotient
);
    import sbph_pkg::*;

    localparam int CNT_W = $clog2(BIN_W);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dsh_reg;
    logic [BIN_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(BIN_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= NUM_W'(divisor) << (BIN_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[BIN_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* rtl/core/spectrum_bin_peak_hold_core.sv */
// Top level of the spectrum bin peak-hold core: bin mapping and held bin values.
// Depends on sbph_pkg and sbph_div.
//
//   Channel   Signals                          Direction
//   item      item_valid, item_stall, item     in  (measurement or clear)
//   result    result_valid, result_stall, res  out (bin values)
//   config    cfg_write, cfg_index, cfg_data   in  (span registers, step ignored)
//
// A measurement passes through the clamp, multiply, divider start, divide and
// finish steps; the bit-serial divider yields one bin index bit per cycle.
// A clear command goes straight from its transfer to the finish step. One item is in
// work at a time, so the next item is taken only after the current one leaves finish.
// Reset clears all held bin values at once; no clearing pass is needed.
// A stalled result holds the core in its final step until it is taken.
`default_nettype none

module spectrum_bin_peak_hold_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire sbph_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output sbph_pkg::result_t                   res,
    input  wire logic                           cfg_write,
    input  wire logic [sbph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sbph_pkg::FREQ_W-1:0]    cfg_data
);
    import sbph_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [FREQ_W-1:0]  span_start_reg;
    logic [FREQ_W-1:0]  span_end_reg;

    item_t              item_reg;
    logic [FREQ_W-1:0]  diff_reg;
    logic [FREQ_W-1:0]  den_reg;
    logic               empty_reg;
    logic [NUM_W-1:0]   prod_reg;

    logic [BIN_W-1:0]   prev_bin_reg;
    logic [LEVEL_W-1:0] peak_reg;
    logic [LEVEL_W-1:0] floor_reg;
    logic               marker_reg;
    logic [BIN_W-1:0]   filled_reg;

    result_t            res_reg;
    logic               res_valid_reg;

    logic               item_take;
    logic               div_start;
    logic               finish;
    logic               div_done;
    logic [BIN_W-1:0]   div_quot;

    logic [FREQ_W-1:0]  freq_clamped;
    logic [BIN_W-1:0]   bin;
    logic [BIN_W:0]     bin_plus;
    logic [LEVEL_W-1:0] peak_base;
    logic [LEVEL_W-1:0] floor_base;
    logic               marker_base;
    logic [LEVEL_W-1:0] peak_new;
    logic [LEVEL_W-1:0] floor_new;
    logic               marker_new;
    logic [BIN_W-1:0]   filled_new;

    sbph_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (item.command == CMD_CLEAR) ? ST_FINISH : ST_CLAMP;
                end
            end
            ST_CLAMP:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_START;
            ST_START:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        div_start  = (state_reg == ST_START);
        finish     = (state_reg == ST_FINISH) && (!res_valid_reg || !result_stall);
    end

    assign item_take = item_valid && !item_stall;

    always_comb
    begin
        if (item_reg.frequency < span_start_reg)
        begin
            freq_clamped = span_start_reg;
        end
        else if (item_reg.frequency > span_end_reg)
        begin
            freq_clamped = span_end_reg;
        end
        else
        begin
            freq_clamped = item_reg.frequency;
        end
    end

    always_comb
    begin
        bin         = empty_reg ? '0 : div_quot;
        bin_plus    = {1'b0, bin} + (BIN_W + 1)'(1);
        peak_base   = (prev_bin_reg != bin) ? '0 : peak_reg;
        floor_base  = (prev_bin_reg != bin) ? FLOOR_MAX : floor_reg;
        marker_base = (prev_bin_reg != bin) ? 1'b0 : marker_reg;
        peak_new    = (item_reg.signal_level > peak_base) ? item_reg.signal_level : peak_base;
        floor_new   = (item_reg.noise_level < floor_base) ? item_reg.noise_level : floor_base;
        marker_new  = marker_base | item_reg.squelch_open;
        filled_new  = (bin_plus > {1'b0, filled_reg}) ? bin_plus[BIN_W-1:0] : filled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            span_start_reg <= '0;
            span_end_reg   <= FREQ_W'(1);
            prev_bin_reg   <= NO_BIN;
            peak_reg       <= '0;
            floor_reg      <= FLOOR_MAX;
            marker_reg     <= 1'b0;
            filled_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SPAN_START: span_start_reg <= cfg_data;
                    CFG_SPAN_END:   span_end_reg   <= cfg_data;
                    // The step size is not stored, so it never changes a result.
                    CFG_STEP_SIZE:  ;
                    default:        ;
                endcase
            end
            if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                res_valid_reg <= 1'b1;
                if (item_reg.command == CMD_CLEAR)
                begin
                    peak_reg   <= '0;
                    floor_reg  <= FLOOR_MAX;
                    marker_reg <= 1'b0;
                    filled_reg <= '0;
                end
                else
                begin
                    prev_bin_reg <= bin;
                    peak_reg     <= peak_new;
                    floor_reg    <= floor_new;
                    marker_reg   <= marker_new;
                    filled_reg   <= filled_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_CLAMP)
        begin
            diff_reg  <= freq_clamped - span_start_reg;
            den_reg   <= span_end_reg - span_start_reg;
            empty_reg <= (span_end_reg <= span_start_reg);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= NUM_W'(diff_reg) * BIN_SCALE;
        end
        if (finish)
        begin
            if (item_reg.command == CMD_CLEAR)
            begin
                res_reg.bin_index    <= '0;
                res_reg.bin_peak     <= '0;
                res_reg.bin_floor    <= FLOOR_MAX;
                res_reg.bin_marker   <= 1'b0;
                res_reg.filled_count <= '0;
            end
            else
            begin
                res_reg.bin_index    <= bin;
                res_reg.bin_peak     <= peak_new;
                res_reg.bin_floor    <= floor_new;
                res_reg.bin_marker   <= marker_new;
                res_reg.filled_count <= filled_new;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign res          = res_reg;

endmodule

`default_nettype wire
